[hw/rtl/life_automaton_torus_unit_macros.svh]
`ifndef LIFE_AUTOMATON_TORUS_UNIT_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LATU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define LATU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define LATU_ASSERT_IMP(lbl, ante, cons)
`define LATU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/latu_pkg.sv]
`timescale 1ns / 1ps
package latu_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int DIM_W      = 9;
  localparam int MODE_W     = 2;
  localparam int IN_COL_W   = 8;
  localparam int IN_ROW_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CNT_W      = 4;

  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = 1'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd210;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd120;

  localparam logic [CNT_W-1:0] BIRTH_COUNT = 4'd3;
  localparam logic [CNT_W-1:0] STAY_COUNT  = 4'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CALC,
    S_CDRAIN,
    S_COPY,
    S_PDRAIN,
    S_RESP
  } state_t;

endpackage

[hw/rtl/latu_in_if.sv]
`timescale 1ns / 1ps
interface latu_in_if;
  logic                          valid;
  logic                          ready;
  logic [latu_pkg::MODE_W-1:0]   mode;
  logic [latu_pkg::IN_COL_W-1:0] col;
  logic [latu_pkg::IN_ROW_W-1:0] row;
  logic                          cell_in;

  modport source (output valid, mode, col, row, cell_in, input ready);
  modport sink (input valid, mode, col, row, cell_in, output ready);
endinterface

[hw/rtl/latu_out_if.sv]
`timescale 1ns / 1ps
interface latu_out_if;
  logic valid;
  logic ready;
  logic cell_out;
  logic step_done;

  modport source (output valid, cell_out, step_done, input ready);
  modport sink (input valid, cell_out, step_done, output ready);
endinterface

[hw/rtl/life_automaton_torus_unit.sv]
`timescale 1ns / 1ps
// Toroidal Game of Life grid, rule B3/S23, up to 256 by 256 one-bit cells.
// Words arrive on in_if (mode, col, row, cell_in) and every word gives one
// result word on out_if (cell_out, step_done). Mode 0 writes a cell, mode 1
// reads a cell, mode 2 advances the whole grid one generation.
// The grid dimensions are set through the cfg_ port; the user must write them
// only while the block is idle, and the block itself does not enforce this.
// A write, a read or the unused mode passes through the response state into
// the output register, and the block returns to idle once the word is loaded.
// An advance fetches each column of three cells one bit per cycle from the
// single read port of the cell memory, width + 2 columns per row, then
// copies the new generation back one cell per cycle.
// The block takes one word at a time and accepts the next one as soon as it
// is idle, even while the previous result waits in the output register.
// If the receiver stalls a second result, the block holds in its response
// state until the output register is free.
// After reset the cell memory is cleared one cell a cycle, all 65536 cells,
// and no word is accepted during that pass; configuration writes are taken.
`include "life_automaton_torus_unit_macros.svh"
module life_automaton_torus_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  latu_in_if.sink                          in_if,
  latu_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [latu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [latu_pkg::DIM_W-1:0]       cfg_wdata
);

  localparam int COL_W  = latu_pkg::COL_W;
  localparam int ROW_W  = latu_pkg::ROW_W;
  localparam int ADDR_W = latu_pkg::ADDR_W;
  localparam int DIM_W  = latu_pkg::DIM_W;
  localparam int CNT_W  = latu_pkg::CNT_W;

  latu_pkg::state_t state_r, state_nxt;

  logic [DIM_W-1:0]  cfg_w_r, cfg_h_r;
  logic [DIM_W-1:0]  w_use, h_use;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [DIM_W-1:0]  row_r, row_nxt;
  logic [DIM_W-1:0]  j_r, j_nxt;
  logic [1:0]        k_r, k_nxt;

  logic in_ready, accept, in_area;
  logic resp_rd_r, resp_step_r;
  logic out_vld_r, out_vld_nxt, out_cell_r, out_step_r, out_load;

  logic cell_mem [latu_pkg::CELLS];
  logic next_mem [latu_pkg::CELLS];
  logic cell_rdata_r, next_rdata_r;

  logic              cm_we, cm_wdata, cm_re;
  logic [ADDR_W-1:0] cm_waddr, cm_raddr;
  logic              nm_re;
  logic [ADDR_W-1:0] nm_raddr;

  logic [DIM_W-1:0] ru, rd, fetch_row, fetch_col, emit_col;

  logic             p1_vld_r, p1_last_r, p1_emit_r;
  logic [COL_W-1:0] p1_col_r, p2_col_r;
  logic [ROW_W-1:0] p1_row_r, p2_row_r;
  logic [1:0]       col_sr_r;
  logic [2:0]       win_l_r, win_m_r, win_r_r;
  logic             p2_emit_r;
  logic [CNT_W-1:0] ncount;
  logic             next_cell;

  logic              q_vld_r;
  logic [ADDR_W-1:0] q_addr_r;

  always_comb begin
    if (cfg_w_r == '0) begin
      w_use = DIM_W'(1);
    end else if (cfg_w_r > DIM_W'(latu_pkg::MAX_WIDTH)) begin
      w_use = DIM_W'(latu_pkg::MAX_WIDTH);
    end else begin
      w_use = cfg_w_r;
    end
    if (cfg_h_r == '0) begin
      h_use = DIM_W'(1);
    end else if (cfg_h_r > DIM_W'(latu_pkg::MAX_HEIGHT)) begin
      h_use = DIM_W'(latu_pkg::MAX_HEIGHT);
    end else begin
      h_use = cfg_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= latu_pkg::WIDTH_RESET;
      cfg_h_r <= latu_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == latu_pkg::CFG_WIDTH_IDX) begin
        cfg_w_r <= cfg_wdata;
      end else begin
        cfg_h_r <= cfg_wdata;
      end
    end
  end

  assign in_ready    = (state_r == latu_pkg::S_IDLE);
  assign in_if.ready = in_ready;
  assign accept      = in_if.valid && in_ready;
  assign in_area     = ({1'b0, in_if.col} < w_use) && ({1'b0, in_if.row} < h_use);

  assign ru = (row_r == '0) ? h_use - DIM_W'(1) : row_r - DIM_W'(1);
  assign rd = (row_r + DIM_W'(1) == h_use) ? '0 : row_r + DIM_W'(1);

  always_comb begin
    unique case (k_r)
      2'd0:    fetch_row = ru;
      2'd1:    fetch_row = row_r;
      default: fetch_row = rd;
    endcase
    if (j_r == '0) begin
      fetch_col = w_use - DIM_W'(1);
    end else if (j_r <= w_use) begin
      fetch_col = j_r - DIM_W'(1);
    end else begin
      fetch_col = '0;
    end
  end

  assign emit_col = j_r - DIM_W'(2);

  always_comb begin
    cm_we    = 1'b0;
    cm_waddr = {in_if.row[ROW_W-1:0], in_if.col[COL_W-1:0]};
    cm_wdata = in_if.cell_in;
    priority if (state_r == latu_pkg::S_CLEAR) begin
      cm_we    = 1'b1;
      cm_waddr = clr_cnt_r;
      cm_wdata = 1'b0;
    end else if (q_vld_r) begin
      cm_we    = 1'b1;
      cm_waddr = q_addr_r;
      cm_wdata = next_rdata_r;
    end else begin
      cm_we = accept && (in_if.mode == latu_pkg::MODE_WRITE) && in_area;
    end
    if (state_r == latu_pkg::S_CALC) begin
      cm_re    = 1'b1;
      cm_raddr = {fetch_row[ROW_W-1:0], fetch_col[COL_W-1:0]};
    end else begin
      cm_re    = accept && (in_if.mode == latu_pkg::MODE_READ);
      cm_raddr = {in_if.row[ROW_W-1:0], in_if.col[COL_W-1:0]};
    end
  end

  assign nm_re    = (state_r == latu_pkg::S_COPY);
  assign nm_raddr = {row_r[ROW_W-1:0], j_r[COL_W-1:0]};

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cell_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      cell_rdata_r <= cell_mem[cm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (p2_emit_r) begin
      next_mem[{p2_row_r, p2_col_r}] <= next_cell;
    end
    if (nm_re) begin
      next_rdata_r <= next_mem[nm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r  <= 1'b0;
      p2_emit_r <= 1'b0;
      q_vld_r   <= 1'b0;
    end else begin
      p1_vld_r  <= (state_r == latu_pkg::S_CALC);
      p2_emit_r <= p1_vld_r && p1_last_r && p1_emit_r;
      q_vld_r   <= nm_re;
    end
  end

  always_ff @(posedge clk) begin
    p1_last_r <= (k_r == 2'd2);
    p1_emit_r <= (j_r >= DIM_W'(2));
    p1_col_r  <= emit_col[COL_W-1:0];
    p1_row_r  <= row_r[ROW_W-1:0];
    p2_col_r  <= p1_col_r;
    p2_row_r  <= p1_row_r;
    q_addr_r  <= nm_raddr;
    if (p1_vld_r) begin
      col_sr_r <= {cell_rdata_r, col_sr_r[1]};
      if (p1_last_r) begin
        win_l_r <= win_m_r;
        win_m_r <= win_r_r;
        win_r_r <= {cell_rdata_r, col_sr_r};
      end
    end
  end

  assign ncount = CNT_W'(win_l_r[0]) + CNT_W'(win_l_r[1]) + CNT_W'(win_l_r[2])
                + CNT_W'(win_m_r[0]) + CNT_W'(win_m_r[2])
                + CNT_W'(win_r_r[0]) + CNT_W'(win_r_r[1]) + CNT_W'(win_r_r[2]);

  assign next_cell = win_m_r[1]
                   ? (ncount == latu_pkg::STAY_COUNT || ncount == latu_pkg::BIRTH_COUNT)
                   : (ncount == latu_pkg::BIRTH_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= latu_pkg::S_CLEAR;
      clr_cnt_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    if (accept) begin
      resp_rd_r   <= (in_if.mode == latu_pkg::MODE_READ) && in_area;
      resp_step_r <= (in_if.mode == latu_pkg::MODE_STEP);
    end
    if (out_load) begin
      out_cell_r <= resp_rd_r && cell_rdata_r;
      out_step_r <= resp_step_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    row_nxt     = row_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    out_load    = 1'b0;
    unique case (state_r)
      latu_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = latu_pkg::S_IDLE;
        end
      end
      latu_pkg::S_IDLE: begin
        if (accept) begin
          row_nxt = '0;
          j_nxt   = '0;
          k_nxt   = '0;
          if (in_if.mode == latu_pkg::MODE_STEP) begin
            state_nxt = latu_pkg::S_CALC;
          end else begin
            state_nxt = latu_pkg::S_RESP;
          end
        end
      end
      latu_pkg::S_CALC: begin
        if (k_r == 2'd2) begin
          k_nxt = '0;
          if (j_r == w_use + DIM_W'(1)) begin
            j_nxt = '0;
            if (row_r + DIM_W'(1) == h_use) begin
              row_nxt   = '0;
              state_nxt = latu_pkg::S_CDRAIN;
            end else begin
              row_nxt = row_r + DIM_W'(1);
            end
          end else begin
            j_nxt = j_r + DIM_W'(1);
          end
        end else begin
          k_nxt = k_r + 2'd1;
        end
      end
      latu_pkg::S_CDRAIN: begin
        if (!p1_vld_r && !p2_emit_r) begin
          row_nxt   = '0;
          j_nxt     = '0;
          state_nxt = latu_pkg::S_COPY;
        end
      end
      latu_pkg::S_COPY: begin
        if (j_r + DIM_W'(1) == w_use) begin
          j_nxt = '0;
          if (row_r + DIM_W'(1) == h_use) begin
            state_nxt = latu_pkg::S_PDRAIN;
          end else begin
            row_nxt = row_r + DIM_W'(1);
          end
        end else begin
          j_nxt = j_r + DIM_W'(1);
        end
      end
      latu_pkg::S_PDRAIN: begin
        if (!q_vld_r) begin
          state_nxt = latu_pkg::S_RESP;
        end
      end
      latu_pkg::S_RESP: begin
        if (!out_vld_r || out_if.ready) begin
          out_load  = 1'b1;
          state_nxt = latu_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = latu_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  assign out_if.valid     = out_vld_r;
  assign out_if.cell_out  = out_cell_r;
  assign out_if.step_done = out_step_r;

  `LATU_ASSERT_IMP(a_emit_in_area, p2_emit_r, (({1'b0, p2_col_r} < w_use) && ({1'b0, p2_row_r} < h_use)))
  `LATU_ASSERT_NXT(a_step_starts, (accept && in_if.mode == latu_pkg::MODE_STEP), (state_r == latu_pkg::S_CALC))
  `LATU_ASSERT_IMP(a_copy_after_calc, (state_r == latu_pkg::S_COPY), (!p1_vld_r && !p2_emit_r))
  `LATU_ASSERT_IMP(a_one_writer, q_vld_r, (!p2_emit_r && state_r != latu_pkg::S_CLEAR))

endmodule
